// ===== rtl/quaternion_vector_rotate_assert.svh =====
// Assertion macros shared by the quaternion vector rotator RTL.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, held off during reset.
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, held off during reset.
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qvr_pkg.sv =====
// Shared constants and width helpers for the quaternion vector rotator.
package qvr_pkg;

  localparam int unsigned VEC_WIDTH   = 24;
  localparam int unsigned QUAT_WIDTH  = 16;
  localparam int unsigned FRAC_SHIFT  = 28;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Width of one component of the first Hamilton product q*v.
  function automatic int unsigned t_width(input int unsigned qw, input int unsigned vw);
    return qw + vw + 2;
  endfunction

endpackage

// ===== rtl/qvr_front.sv =====
// Front end: accepts transactions and forms the first product t = q*v.
module qvr_front #(
  parameter int unsigned QW = qvr_pkg::QUAT_WIDTH,
  parameter int unsigned VW = qvr_pkg::VEC_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_valid_i,
  output logic                                   s_ready_o,
  input  logic [4*QW-1:0]                        quat_i,
  input  logic [3*VW-1:0]                        vec_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output logic [4*qvr_pkg::t_width(QW, VW)+4*QW-1:0] push_data_o
);

  localparam int unsigned TW  = qvr_pkg::t_width(QW, VW);
  localparam int unsigned P1W = QW + VW;

  logic signed [QW-1:0]  q_a [4];
  logic signed [VW-1:0]  v_a [3];
  logic signed [P1W-1:0] p_q [12];
  logic [4*QW-1:0]       q_q;
  logic                  f1_valid_q;
  logic                  en;
  logic signed [TW-1:0]  tx, ty, tz, tw;

  always_comb begin
    for (int i = 0; i < 4; i++) q_a[i] = $signed(quat_i[i*QW +: QW]);
    for (int i = 0; i < 3; i++) v_a[i] = $signed(vec_i[i*VW +: VW]);
  end

  assign en        = !f1_valid_q || push_ready_i;
  assign s_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= s_valid_i;
    end
  end

  // q index: x=0 y=1 z=2 w=3; v index: x=0 y=1 z=2
  always_ff @(posedge clk_i) begin
    if (en && s_valid_i) begin
      p_q[0]  <= q_a[3] * v_a[0];
      p_q[1]  <= q_a[1] * v_a[2];
      p_q[2]  <= q_a[2] * v_a[1];
      p_q[3]  <= q_a[3] * v_a[1];
      p_q[4]  <= q_a[0] * v_a[2];
      p_q[5]  <= q_a[2] * v_a[0];
      p_q[6]  <= q_a[3] * v_a[2];
      p_q[7]  <= q_a[0] * v_a[1];
      p_q[8]  <= q_a[1] * v_a[0];
      p_q[9]  <= q_a[0] * v_a[0];
      p_q[10] <= q_a[1] * v_a[1];
      p_q[11] <= q_a[2] * v_a[2];
      q_q     <= quat_i;
    end
  end

  always_comb begin
    tx = TW'(p_q[0]) + TW'(p_q[1]) - TW'(p_q[2]);
    ty = TW'(p_q[3]) - TW'(p_q[4]) + TW'(p_q[5]);
    tz = TW'(p_q[6]) + TW'(p_q[7]) - TW'(p_q[8]);
    tw = -TW'(p_q[9]) - TW'(p_q[10]) - TW'(p_q[11]);
  end

  assign push_valid_o = f1_valid_q;
  assign push_data_o  = {q_q, tw, tz, ty, tx};

endmodule

// ===== rtl/qvr_queue.sv =====
// Small first-word-fall-through queue between front and back ends.
`include "quaternion_vector_rotate_assert.svh"

module qvr_queue #(
  parameter int unsigned DEPTH = qvr_pkg::QUEUE_DEPTH,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `QVR_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count beyond depth")
  `QVR_ASSERT_IMP(a_empty_ptrs, count_q == '0, wr_ptr_q == rd_ptr_q, "pointers differ when empty")
  `QVR_ASSERT_NXT(a_push_count, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

// ===== rtl/qvr_back.sv =====
// Back end: second product t*conj(q), round half up, saturate, output register.
`include "quaternion_vector_rotate_assert.svh"

module qvr_back #(
  parameter int unsigned QW = qvr_pkg::QUAT_WIDTH,
  parameter int unsigned VW = qvr_pkg::VEC_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   rd_valid_i,
  output logic                                   rd_ready_o,
  input  logic [4*qvr_pkg::t_width(QW, VW)+4*QW-1:0] rd_data_i,
  output logic                                   m_valid_o,
  input  logic                                   m_ready_i,
  output logic [3*VW-1:0]                        rot_o,
  output logic                                   sat_o
);

  localparam int unsigned TW   = qvr_pkg::t_width(QW, VW);
  localparam int unsigned TLO  = TW / 2;
  localparam int unsigned THI  = TW - TLO;
  localparam int unsigned LPW  = TLO + 1 + QW;
  localparam int unsigned HPW  = THI + QW;
  localparam int unsigned LSW  = LPW + 2;
  localparam int unsigned HSW  = HPW + 2;
  localparam int unsigned RW   = HSW + TLO;
  localparam int unsigned AW   = (RW > 64) ? 64 : RW;
  localparam int unsigned FRAC = qvr_pkg::FRAC_SHIFT;
  localparam int unsigned EW   = (AW > FRAC + VW + 1) ? AW : FRAC + VW + 1;
  localparam int unsigned SW   = EW - FRAC;

  localparam logic signed [VW-1:0] ROT_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] ROT_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [EW-1:0] HALF    = {{(EW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  // term k of component k/4: sign * t[term_t(k)] * q[term_q(k)]; x=0 y=1 z=2 w=3
  function automatic logic [1:0] term_t(input int k);
    case (k)
      0, 6, 10:  return 2'd0;
      1, 5, 9:   return 2'd3;
      2, 4, 11:  return 2'd1;
      default:   return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] term_q(input int k);
    case (k)
      0, 4, 8:   return 2'd3;
      1, 7:      return 2'd0;
      2, 6, 9:   return 2'd2;
      5, 10:     return 2'd1;
      3:         return 2'd1;
      11:        return 2'd0;
      default:   return 2'd0;
    endcase
  endfunction

  function automatic logic term_neg(input int k);
    case (k)
      1, 2, 5, 7, 9, 10: return 1'b1;
      default:           return 1'b0;
    endcase
  endfunction

  logic signed [TW-1:0]  t_a [4];
  logic signed [QW-1:0]  q_a [4];
  logic signed [LPW-1:0] lo_d [12], lo_q [12];
  logic signed [HPW-1:0] hi_d [12], hi_q [12];
  logic signed [LSW-1:0] lo_s [3];
  logic signed [HSW-1:0] hi_s [3];
  logic signed [RW-1:0]  r_full [3];
  logic signed [AW-1:0]  r_d [3], r_q [3];
  logic signed [EW-1:0]  s_v [3];
  logic signed [SW-1:0]  sh [3];
  logic signed [VW-1:0]  rot_d [3], rot_q [3];
  logic [2:0]            clip;
  logic                  sat_q;
  logic                  b1_valid_q, b2_valid_q, b3_valid_q;
  logic                  en;
  logic                  at_rail;
  logic                  stalled;

  assign en         = !b3_valid_q || m_ready_i;
  assign rd_ready_o = en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_a[i] = $signed(rd_data_i[i*TW +: TW]);
      q_a[i] = $signed(rd_data_i[4*TW + i*QW +: QW]);
    end
    for (int k = 0; k < 12; k++) begin
      lo_d[k] = $signed({1'b0, t_a[term_t(k)][TLO-1:0]}) * q_a[term_q(k)];
      hi_d[k] = $signed(t_a[term_t(k)][TW-1:TLO]) * q_a[term_q(k)];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_s[c] = '0;
      hi_s[c] = '0;
      for (int j = 0; j < 4; j++) begin
        if (term_neg(c*4 + j)) begin
          lo_s[c] = lo_s[c] - LSW'(lo_q[c*4 + j]);
          hi_s[c] = hi_s[c] - HSW'(hi_q[c*4 + j]);
        end else begin
          lo_s[c] = lo_s[c] + LSW'(lo_q[c*4 + j]);
          hi_s[c] = hi_s[c] + HSW'(hi_q[c*4 + j]);
        end
      end
      r_full[c] = (RW'(hi_s[c]) <<< TLO) + RW'(lo_s[c]);
      r_d[c]    = $signed(r_full[c][AW-1:0]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_v[c] = EW'(r_q[c]) + HALF;
      sh[c]  = $signed(s_v[c][EW-1:FRAC]);
      if (sh[c] > SW'(ROT_MAX)) begin
        rot_d[c] = ROT_MAX;
        clip[c]  = 1'b1;
      end else if (sh[c] < SW'(ROT_MIN)) begin
        rot_d[c] = ROT_MIN;
        clip[c]  = 1'b1;
      end else begin
        rot_d[c] = $signed(sh[c][VW-1:0]);
        clip[c]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q <= rd_valid_i;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rd_valid_i) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
      if (b1_valid_q) begin
        r_q <= r_d;
      end
      if (b2_valid_q) begin
        rot_q <= rot_d;
        sat_q <= |clip;
      end
    end
  end

  assign m_valid_o = b3_valid_q;
  assign rot_o     = {rot_q[2], rot_q[1], rot_q[0]};
  assign sat_o     = sat_q;

  assign at_rail = (rot_q[0] == ROT_MAX) || (rot_q[0] == ROT_MIN) ||
                   (rot_q[1] == ROT_MAX) || (rot_q[1] == ROT_MIN) ||
                   (rot_q[2] == ROT_MAX) || (rot_q[2] == ROT_MIN);
  assign stalled = m_valid_o && !m_ready_i;

  `QVR_ASSERT_IMP(a_sat_at_rail, m_valid_o && sat_q, at_rail, "flag set with no clipped component")
  `QVR_ASSERT_NXT(a_stall_holds, stalled, m_valid_o && $stable({sat_o, rot_o}), "stalled result changed")

endmodule

// ===== rtl/quaternion_vector_rotate.sv =====
// Quaternion vector rotator top level: stream ports, front end, queue, back end.
//
// Rotates a signed vector by a Q1.14 quaternion, v' = q*v*conj(q), taking the
// quaternion as given (a non-unit q scales the result by its squared norm).
// Slave channel: one transaction carries quat x, y, z, w and vec x, y, z.
// Master channel: one transaction carries rot x, y, z; tuser flags saturation.
// Each component is the exact product sum shifted right by 28 with round half
// up, clamped to the vector width.
// Throughput: one transaction per cycle while the receiver is ready, set by the
// fully pipelined stages (one in the front end, three in the back end).
// Path: an accepted input passes the front-end product register, the queue and
// the back-end product, sum and output registers before its result is presented.
// Stall: a stalled receiver freezes the back end; the front end keeps taking
// input until the 4-entry queue fills, then drops s_axis_tready_o.
// Reset: asynchronous, active low; clears all valid flags and the queue.
module quaternion_vector_rotate #(
  parameter int unsigned VEC_WIDTH  = qvr_pkg::VEC_WIDTH,
  parameter int unsigned QUAT_WIDTH = qvr_pkg::QUAT_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero pad
  input  logic [((4*QUAT_WIDTH+3*VEC_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // rot_x, rot_y, rot_z, zero pad
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // saturated
  output logic [0:0] m_axis_tuser_o
);

  localparam int unsigned TW       = qvr_pkg::t_width(QUAT_WIDTH, VEC_WIDTH);
  localparam int unsigned QDW      = 4*TW + 4*QUAT_WIDTH;
  localparam int unsigned OUT_BITS = ((3*VEC_WIDTH + 7) / 8) * 8;

  logic                      push_valid, push_ready, pop_valid, pop_ready;
  logic [QDW-1:0]            push_data, pop_data;
  logic [3*VEC_WIDTH-1:0]    rot;
  logic                      sat;

  qvr_front #(
    .QW(QUAT_WIDTH),
    .VW(VEC_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .quat_i       (s_axis_tdata_i[4*QUAT_WIDTH-1:0]),
    .vec_i        (s_axis_tdata_i[4*QUAT_WIDTH +: 3*VEC_WIDTH]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  qvr_queue #(
    .DEPTH(qvr_pkg::QUEUE_DEPTH),
    .WIDTH(QDW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  qvr_back #(
    .QW(QUAT_WIDTH),
    .VW(VEC_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (pop_valid),
    .rd_ready_o (pop_ready),
    .rd_data_i  (pop_data),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .rot_o      (rot),
    .sat_o      (sat)
  );

  assign m_axis_tdata_o = OUT_BITS'(rot);
  assign m_axis_tuser_o = sat;

endmodule
